[rtl/core/aesc_pkg.sv]
// Shared types and constants for the arithmetic expression syntax checker.
`timescale 1ns / 1ps
`default_nettype none
package aesc_pkg;

  // Class of the previous character
  typedef enum logic [2:0] {
    CL_NONE        = 3'd0,
    CL_OTHER       = 3'd1,
    CL_OP          = 3'd2,
    CL_OPEN        = 3'd3,
    CL_CLOSE       = 3'd4,
    CL_CLOSE_FIRST = 3'd5
  } char_class_t;

  // Reported error group, first failing group wins
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_OP      = 3'd1,
    ERR_ILLEGAL = 3'd2,
    ERR_BRACKET = 3'd3,
    ERR_DOTS    = 3'd4
  } err_kind_t;

  // Sticky flag bit positions
  localparam int unsigned FL_OP      = 0;
  localparam int unsigned FL_ILLEGAL = 1;
  localparam int unsigned FL_BRACKET = 2;
  localparam int unsigned FL_DOTS    = 3;
  localparam int unsigned FLAG_W     = 4;

  typedef logic [FLAG_W-1:0] err_flags_t;

  // Depth-independent part of the tracking state
  typedef struct packed {
    char_class_t prev_class;
    logic        dot_in_number;
    err_flags_t  flags;
  } track_state_t;

  localparam track_state_t TRACK_RESET = '{
    prev_class:    CL_NONE,
    dot_in_number: 1'b0,
    flags:         '0
  };

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage
`default_nettype wire

[rtl/core/arith_expr_syntax_checker.sv]
// Top level of the arithmetic expression syntax checker.
`timescale 1ns / 1ps
`default_nettype none
// Takes one expression character per transfer on the in_ channel, with
// in_is_last marking the final character, and returns one out_error_kind
// transfer per expression (0 valid, 1 operator placement, 2 illegal
// character, 3 bracket, 4 multiple dots; first failing group wins).
// Characters other than the last produce no result. Throughput is one
// character per cycle: an input register feeds the rule checks and the
// state update, which finish in that cycle, and the verdict lands in an
// output register. out_valid is registered and rises when the verdict
// for the last character in the input register is written there.
// The input side only holds off when a last character waits in the input
// register while the output register still holds an untaken verdict.
// Bracket depth is a signed counter saturating at +/-MAX_DEPTH;
// saturation is reported as a bracket error.
module arith_expr_syntax_checker #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_error_kind
);

  // sign bit plus magnitude up to MAX_DEPTH
  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1) + 1;

  // input register
  logic                          s1_valid_r, s1_valid_nxt;
  logic [7:0]                    s1_char_r;
  logic                          s1_last_r;

  // tracking state
  aesc_pkg::track_state_t        trk_r, trk_nxt;
  logic signed [DEPTH_W-1:0]     depth_r, depth_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  aesc_pkg::err_kind_t           out_kind_r, step_kind;

  logic                          out_free, s1_go;

  // a last character needs room in the output register
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  aesc_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W)
  ) u_step (
    .char_code (s1_char_r),
    .is_last   (s1_last_r),
    .cur       (trk_r),
    .depth     (depth_r),
    .nxt       (trk_nxt),
    .depth_nxt (depth_nxt),
    .err_kind  (step_kind)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r)    out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      trk_r       <= aesc_pkg::TRACK_RESET;
      depth_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        trk_r   <= trk_nxt;
        depth_r <= depth_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
    if (s1_go && s1_last_r) begin
      out_kind_r <= step_kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_error_kind = out_kind_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // finishing an expression returns tracking to its start state
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=>
      (trk_r.prev_class == aesc_pkg::CL_NONE) && (depth_r == '0) && (trk_r.flags == '0))
    else $error("tracking state not cleared after last character");

  // depth never leaves the saturation window
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r <= $signed(DEPTH_W'(MAX_DEPTH))) && (depth_r >= -$signed(DEPTH_W'(MAX_DEPTH))))
    else $error("bracket depth out of range");

  // a new verdict only comes from a processed last character
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_last_r))
    else $error("result appeared without a last character");

  // a last character never overwrites an untaken verdict
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |-> (!out_valid_r || out_ready))
    else $error("verdict overwritten");

endmodule
`default_nettype wire

[rtl/core/aesc_step.sv]
// Per-character rule checks and tracking state update.
`timescale 1ns / 1ps
`default_nettype none
module aesc_step #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned DEPTH_W   = 9
) (
  input  wire logic [7:0]                char_code,
  input  wire logic                      is_last,
  input  wire aesc_pkg::track_state_t    cur,
  input  wire logic signed [DEPTH_W-1:0] depth,
  output aesc_pkg::track_state_t         nxt,
  output logic signed [DEPTH_W-1:0]      depth_nxt,
  output aesc_pkg::err_kind_t            err_kind
);

  localparam logic signed [DEPTH_W-1:0] DEPTH_HI = DEPTH_W'(MAX_DEPTH);
  localparam logic signed [DEPTH_W-1:0] DEPTH_LO = -DEPTH_HI;

  logic                          is_op, is_op_nm, is_open, is_close, is_dot, is_digit;
  aesc_pkg::err_flags_t          fl;
  aesc_pkg::char_class_t         cls;
  logic signed [DEPTH_W-1:0]     d;
  logic                          dot;

  always_comb begin
    is_op_nm = (char_code == aesc_pkg::CH_PLUS) || (char_code == aesc_pkg::CH_STAR) ||
               (char_code == aesc_pkg::CH_SLASH);
    is_op    = is_op_nm || (char_code == aesc_pkg::CH_MINUS);
    is_open  = (char_code == aesc_pkg::CH_OPEN);
    is_close = (char_code == aesc_pkg::CH_CLOSE);
    is_dot   = (char_code == aesc_pkg::CH_DOT) || (char_code == aesc_pkg::CH_COMMA);
    is_digit = (char_code >= aesc_pkg::CH_ZERO) && (char_code <= aesc_pkg::CH_NINE);

    fl = cur.flags;
    // operator placement
    if ((cur.prev_class == aesc_pkg::CL_NONE) && is_op_nm) fl[aesc_pkg::FL_OP] = 1'b1;
    if ((cur.prev_class == aesc_pkg::CL_OP) && is_op)      fl[aesc_pkg::FL_OP] = 1'b1;
    if (is_last && is_op)                                  fl[aesc_pkg::FL_OP] = 1'b1;
    // illegal character
    if (!(is_digit || is_op || is_open || is_close || is_dot))
      fl[aesc_pkg::FL_ILLEGAL] = 1'b1;
    // bracket neighbors
    if ((cur.prev_class == aesc_pkg::CL_OPEN) && is_op_nm) fl[aesc_pkg::FL_BRACKET] = 1'b1;
    if (is_close && (cur.prev_class == aesc_pkg::CL_OP))   fl[aesc_pkg::FL_BRACKET] = 1'b1;
    if (is_open && (cur.prev_class != aesc_pkg::CL_NONE) &&
        (cur.prev_class != aesc_pkg::CL_OP) && (cur.prev_class != aesc_pkg::CL_OPEN))
      fl[aesc_pkg::FL_BRACKET] = 1'b1;
    if ((cur.prev_class == aesc_pkg::CL_CLOSE) && !is_op && !is_close)
      fl[aesc_pkg::FL_BRACKET] = 1'b1;

    // depth, saturating at the limits
    d = depth;
    if (is_open) begin
      if (depth >= DEPTH_HI) fl[aesc_pkg::FL_BRACKET] = 1'b1;
      else                   d = depth + DEPTH_W'(1);
    end else if (is_close) begin
      if (depth <= DEPTH_LO) fl[aesc_pkg::FL_BRACKET] = 1'b1;
      else                   d = depth - DEPTH_W'(1);
    end

    // dots within one number
    dot = cur.dot_in_number;
    if (is_dot) begin
      if (cur.dot_in_number) fl[aesc_pkg::FL_DOTS] = 1'b1;
      dot = 1'b1;
    end else if (is_op || is_open || is_close) begin
      dot = 1'b0;
    end

    if (is_op)         cls = aesc_pkg::CL_OP;
    else if (is_open)  cls = aesc_pkg::CL_OPEN;
    else if (is_close) cls = (cur.prev_class == aesc_pkg::CL_NONE) ?
                             aesc_pkg::CL_CLOSE_FIRST : aesc_pkg::CL_CLOSE;
    else               cls = aesc_pkg::CL_OTHER;

    // unbalanced at end
    if (is_last && (d != '0)) fl[aesc_pkg::FL_BRACKET] = 1'b1;

    if (fl[aesc_pkg::FL_OP])           err_kind = aesc_pkg::ERR_OP;
    else if (fl[aesc_pkg::FL_ILLEGAL]) err_kind = aesc_pkg::ERR_ILLEGAL;
    else if (fl[aesc_pkg::FL_BRACKET]) err_kind = aesc_pkg::ERR_BRACKET;
    else if (fl[aesc_pkg::FL_DOTS])    err_kind = aesc_pkg::ERR_DOTS;
    else                               err_kind = aesc_pkg::ERR_NONE;

    // back to start-of-expression after the last character
    if (is_last) begin
      nxt       = aesc_pkg::TRACK_RESET;
      depth_nxt = '0;
    end else begin
      nxt.prev_class    = cls;
      nxt.dot_in_number = dot;
      nxt.flags         = fl;
      depth_nxt         = d;
    end
  end

endmodule
`default_nettype wire
